/* hdl/text_terminal_cursor_scroll_assert.svh */
// ---------------------------------------------------------------------------
// Text terminal assertion macros
// Shorthand for the concurrent checks at the end of the terminal top level.
// ---------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_CURSOR_SCROLL_ASSERT_SVH
`define TEXT_TERMINAL_CURSOR_SCROLL_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define TCS_ASSERT_HOLDS(label, clk_s, rst_s, expr, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (expr)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define TCS_ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) else $error(msg);

`endif

/* hdl/tcs_pkg.sv */
// ---------------------------------------------------------------------------
// Text terminal package
// Cell types and character constants shared by the terminal logic.
// ---------------------------------------------------------------------------
`default_nettype none

package tcs_pkg;

  typedef logic [7:0]  char_t;
  typedef logic [7:0]  attr_t;
  typedef logic [15:0] cell_t;
  typedef logic [10:0] index_t;

  // Request kinds on the mode field.
  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam char_t NEWLINE_CODE = 8'd10;
  localparam char_t SPACE_CODE   = 8'd32;
  localparam attr_t RESET_COLOR  = 8'h07;
  localparam cell_t RESET_CELL   = {RESET_COLOR, SPACE_CODE};

endpackage

`default_nettype wire

/* hdl/text_terminal_cursor_scroll.sv */
// A character terminal that owns a ROWS x COLUMNS screen of 16-bit cells
// (character in the low byte, attribute in the high byte). A put request
// writes a character at the cursor and advances it, or moves to the next
// line on a newline; a read request returns one cell, zero for an index
// past the screen. An accepted put or read goes to S_RD_DATA or S_FINISH,
// where the result register loads once the output register is free, and
// the next request is taken back in S_IDLE. A put that runs off the bottom
// row scrolls the screen: each cell below the top row is copied up one row
// through the single screen RAM, one cell per cycle over its one read and
// one write port. After reset all ROWS*COLUMNS cells of the RAM are swept
// to grey spaces one cell per cycle, during which no request is accepted;
// the color register is writable at any time. One request is in flight at
// a time, and the next request is taken while the previous result waits
// in the output register.
`default_nettype none
`include "text_terminal_cursor_scroll_assert.svh"

module text_terminal_cursor_scroll #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire                 clk,
  input  wire                 rst,
  // Color register write
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire tcs_pkg::attr_t text_color,
  // Request channel
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire                 mode,
  input  wire tcs_pkg::char_t char_code,
  input  wire tcs_pkg::index_t read_index,
  // Result channel
  output logic                out_valid,
  input  wire                 out_ready,
  output tcs_pkg::cell_t      cell_value,
  output logic [4:0]          cursor_row,
  output logic [6:0]          cursor_col,
  output logic                scrolled
);

  import tcs_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CLW   = $clog2(COLUMNS);
  localparam int CW    = (AW >= 11) ? AW + 1 : 11;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_DATA,
    S_SCR_PRIME,
    S_SCROLL,
    S_FINISH
  } state_t;

  state_t          state;
  attr_t           attr;
  logic [RW-1:0]   row;
  logic [CLW-1:0]  col;
  logic [AW-1:0]   row_base;
  logic [AW-1:0]   cur_addr;
  logic [AW-1:0]   ptr;
  cell_t           res_cell;
  logic            res_scrolled;

  logic            accept;
  logic            out_free;
  logic            load_out;
  logic            put_char;
  logic            wrap;
  logic            last_row;
  logic [CW-1:0]   idx_wide;
  logic            idx_hit;
  logic [AW:0]     src;
  logic            src_hit;
  logic            copy_cell;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  cell_t           ram_wdata;
  logic [AW-1:0]   ram_raddr;
  cell_t           ram_rdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign load_out  = ((state == S_RD_DATA) || (state == S_FINISH)) && out_free;

  // Request decode and cursor wrap.
  assign put_char = (mode == MODE_PUT) && (char_code != NEWLINE_CODE);
  assign wrap     = (char_code == NEWLINE_CODE) || (col == CLW'(COLUMNS - 1));
  assign last_row = (row == RW'(ROWS - 1));
  assign idx_wide = CW'(read_index);
  assign idx_hit  = idx_wide < CW'(CELLS);

  // Scroll source is one row ahead of the destination, read in the cycle before its write.
  assign src       = {1'b0, ptr} + (AW + 1)'(COLUMNS + 1);
  assign src_hit   = src < (AW + 1)'(CELLS);
  assign copy_cell = ptr < AW'(CELLS - COLUMNS);

  // Screen RAM port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = RESET_CELL;
    ram_raddr = idx_hit ? idx_wide[AW-1:0] : '0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        if (accept && put_char) begin
          ram_we    = 1'b1;
          ram_waddr = cur_addr;
          ram_wdata = {attr, char_code};
        end
      end
      S_SCR_PRIME: begin
        ram_raddr = AW'(COLUMNS);
      end
      S_SCROLL: begin
        ram_we    = 1'b1;
        ram_wdata = copy_cell ? ram_rdata : {attr, SPACE_CODE};
        ram_raddr = src_hit ? src[AW-1:0] : '0;
      end
      default: begin
      end
    endcase
  end

  tcs_ram #(
    .WIDTH ($bits(cell_t)),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Whether the read request just accepted fell inside the screen.
  logic rd_hit;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_hit <= idx_hit;
    end
  end

  function automatic cell_t res_hit_sel(input cell_t data);
    return rd_hit ? data : '0;
  endfunction

  // Sequencer, cursor and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      attr         <= RESET_COLOR;
      row          <= '0;
      col          <= '0;
      row_base     <= '0;
      cur_addr     <= '0;
      ptr          <= '0;
      out_valid    <= 1'b0;
      res_scrolled <= 1'b0;
    end else begin
      if (cfg_valid) begin
        attr <= text_color;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (ptr == AW'(CELLS - 1)) begin
            ptr   <= '0;
            state <= S_IDLE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_cell     <= '0;
            res_scrolled <= (mode == MODE_PUT) && wrap && last_row;
            if (mode == MODE_READ) begin
              state <= S_RD_DATA;
            end else if (!wrap) begin
              col      <= col + 1'b1;
              cur_addr <= cur_addr + 1'b1;
              state    <= S_FINISH;
            end else if (last_row) begin
              col      <= '0;
              cur_addr <= row_base;
              state    <= S_SCR_PRIME;
            end else begin
              col      <= '0;
              row      <= row + 1'b1;
              row_base <= row_base + AW'(COLUMNS);
              cur_addr <= row_base + AW'(COLUMNS);
              state    <= S_FINISH;
            end
          end
        end
        S_RD_DATA: begin
          // The index was checked at acceptance; a miss reads as zero.
          if (out_free) begin
            cell_value   <= res_hit_sel(ram_rdata);
            cursor_row   <= 5'(row);
            cursor_col   <= 7'(col);
            scrolled     <= 1'b0;
            state        <= S_IDLE;
          end else begin
            res_cell <= res_hit_sel(ram_rdata);
            state    <= S_FINISH;
          end
        end
        S_SCR_PRIME: begin
          ptr   <= '0;
          state <= S_SCROLL;
        end
        S_SCROLL: begin
          if (ptr == AW'(CELLS - 1)) begin
            ptr   <= '0;
            state <= S_FINISH;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            cell_value <= res_cell;
            cursor_row <= 5'(row);
            cursor_col <= 7'(col);
            scrolled   <= res_scrolled;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Cursor never leaves the screen.
  `TCS_ASSERT_HOLDS(a_cursor_in_bounds, clk, rst,
    (int'(col) < COLUMNS) && (int'(row) < ROWS), "cursor outside the screen")

  // Every put other than a newline writes the screen at the cursor in its accept cycle.
  `TCS_ASSERT_IMPLIES(a_put_writes, clk, rst,
    accept && put_char, ram_we && (ram_waddr == cur_addr), "put did not write the cursor cell")

  // A scroll always leaves the cursor at the start of the bottom row.
  `TCS_ASSERT_IMPLIES(a_scroll_cursor, clk, rst,
    out_valid && scrolled, (cursor_row == 5'(ROWS - 1)) && (cursor_col == 7'd0),
    "scroll result with cursor off the bottom row start")

endmodule

`default_nettype wire

/* hdl/tcs_ram.sv */
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module tcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* test/text_terminal_cursor_scroll_tb.sv */
// ----------------------------------------------------------------------------
// Text terminal cursor and scroll testbench
// Drives put and read requests into the terminal. A scoreboard keeps its own
// copy of the screen, cursor and text color, and checks every result field
// against it. The color register is changed between phases while the block
// is idle. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module text_terminal_cursor_scroll_tb;
  import tcs_pkg::*;

  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int CELL_COUNT    = COLUMNS * ROWS;
  localparam int RANDOM_ITEMS  = 1430;
  localparam int PHASES        = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 20_000_000;
  localparam int IDLE_PCT      = 19;

  // One expected or observed result of a request.
  typedef struct packed {
    cell_t      cell_data;
    logic [4:0] row;
    logic [6:0] col;
    logic       did_scroll;
  } term_result_t;

  // Keeps a private copy of the screen and cursor, and the results still due.
  class term_scoreboard;
    cell_t        screen [CELL_COUNT];
    int unsigned  row_pos;
    int unsigned  col_pos;
    attr_t        color;
    term_result_t results_due [$];
    int unsigned  error_count;
    int unsigned  checked_count;
    int unsigned  put_count;
    int unsigned  read_count;
    int unsigned  scroll_count;

    function new();
      foreach (screen[i]) screen[i] = RESET_CELL;
      row_pos = 0;
      col_pos = 0;
      color   = RESET_COLOR;
      error_count   = 0;
      checked_count = 0;
      put_count     = 0;
      read_count    = 0;
      scroll_count  = 0;
    endfunction

    function void set_color(attr_t c);
      color = c;
    endfunction

    function int unsigned pending_count();
      return results_due.size();
    endfunction

    // Move to the start of the next row; past the bottom, the screen moves up
    // one row and the bottom row is blanked in the current color.
    function bit next_line();
      col_pos = 0;
      row_pos++;
      if (row_pos < ROWS) return 1'b0;
      for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen[i] = {color, SPACE_CODE};
      row_pos = ROWS - 1;
      scroll_count++;
      return 1'b1;
    endfunction

    // Work out the result of an accepted request and queue it.
    function void note_request(logic req_mode, char_t ch, index_t idx);
      term_result_t r;
      r = '0;
      if (req_mode == MODE_READ) begin
        read_count++;
        if (idx < CELL_COUNT) r.cell_data = screen[idx];
      end else begin
        put_count++;
        if (ch == NEWLINE_CODE) begin
          r.did_scroll = next_line();
        end else begin
          screen[row_pos * COLUMNS + col_pos] = {color, ch};
          col_pos++;
          if (col_pos >= COLUMNS) r.did_scroll = next_line();
        end
      end
      r.row = 5'(row_pos);
      r.col = 7'(col_pos);
      results_due.push_back(r);
    endfunction

    // Compare one observed result with the oldest one still due.
    function void check_result(term_result_t got);
      term_result_t want;
      if (results_due.size() == 0) begin
        error_count++;
        $display("%0t: result with no request outstanding: cell %h row %0d col %0d scroll %0b",
                 $time, got.cell_data, got.row, got.col, got.did_scroll);
        return;
      end
      want = results_due.pop_front();
      checked_count++;
      if (got.cell_data !== want.cell_data) begin
        error_count++;
        $display("%0t: cell_value mismatch: expected %h, actual %h", $time,
                 want.cell_data, got.cell_data);
      end
      if (got.row !== want.row) begin
        error_count++;
        $display("%0t: cursor_row mismatch: expected %0d, actual %0d", $time, want.row, got.row);
      end
      if (got.col !== want.col) begin
        error_count++;
        $display("%0t: cursor_col mismatch: expected %0d, actual %0d", $time, want.col, got.col);
      end
      if (got.did_scroll !== want.did_scroll) begin
        error_count++;
        $display("%0t: scrolled mismatch: expected %0b, actual %0b", $time,
                 want.did_scroll, got.did_scroll);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  attr_t      text_color;
  logic       in_valid;
  logic       in_ready;
  logic       mode;
  char_t      char_code;
  index_t     read_index;
  logic       out_valid;
  logic       out_ready;
  cell_t      cell_value;
  logic [4:0] cursor_row;
  logic [6:0] cursor_col;
  logic       scrolled;

  term_scoreboard sb;
  bit             steady;
  int unsigned    cycle_count;
  int unsigned    line_left;

  text_terminal_cursor_scroll #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .text_color(text_color),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .char_code (char_code),
    .read_index(read_index),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cell_value(cell_value),
    .cursor_row(cursor_row),
    .cursor_col(cursor_col),
    .scrolled  (scrolled)
  );

  // Clock generation.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Cycle counter and the guard against a hung run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles", cycle_count);
    $display("FAILED: results differ");
    $finish;
  end

  // Result side: stall at random, except during the steady stretch.
  always @(negedge clk) begin
    out_ready = steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Check every result taken from the block.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result('{cell_data: cell_value, row: cursor_row, col: cursor_col,
                        did_scroll: scrolled});
    end
  end

  // Send one request and note it once the block takes it.
  task automatic send_request(logic req_mode, char_t ch, index_t idx);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    mode       = req_mode;
    char_code  = ch;
    read_index = idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req_mode, ch, idx);
  endtask

  // Stop requesting and wait until every result is back.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the color register.
  task automatic write_color(attr_t c);
    @(negedge clk);
    cfg_valid  = 1'b1;
    text_color = c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_color(c);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mixed random traffic: mostly lines of text ended by newlines, reads aimed
  // at the cursor row, the bottom row, anywhere on the screen and past it, and some noise.
  task automatic run_random(int unsigned count, int unsigned phase);
    int unsigned pick;
    int unsigned sel;
    index_t      idx;
    for (int unsigned n = 0; n < count; n++) begin
      steady = (phase == 1) && (n < 250);
      pick = $urandom_range(99);
      if (pick < 30) begin
        sel = $urandom_range(99);
        if (sel < 45) begin
          idx = index_t'(sb.row_pos * COLUMNS + $urandom_range(COLUMNS - 1));
        end else if (sel < 60) begin
          idx = index_t'((ROWS - 1) * COLUMNS + $urandom_range(COLUMNS - 1));
        end else if (sel < 85) begin
          idx = index_t'($urandom_range(CELL_COUNT - 1));
        end else begin
          idx = index_t'($urandom_range(2047, CELL_COUNT));
        end
        send_request(MODE_READ, char_t'($urandom_range(255)), idx);
      end else if (pick < 35) begin
        send_request(MODE_PUT, char_t'($urandom_range(255)), index_t'($urandom_range(2047)));
      end else if (line_left == 0) begin
        send_request(MODE_PUT, NEWLINE_CODE, index_t'($urandom_range(2047)));
        sel = $urandom_range(99);
        if (sel < 10) line_left = 0;
        else if (sel < 80) line_left = $urandom_range(30, 1);
        else line_left = $urandom_range(COLUMNS + 5, COLUMNS - 5);
      end else begin
        send_request(MODE_PUT, char_t'($urandom_range(255)), index_t'($urandom_range(2047)));
        line_left--;
      end
    end
    steady = 1'b0;
  endtask

  // Main sequence.
  initial begin
    attr_t phase_colors [PHASES];
    sb         = new();
    steady     = 1'b0;
    line_left  = 5;
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    text_color = '0;
    in_valid   = 1'b0;
    mode       = MODE_PUT;
    char_code  = '0;
    read_index = '0;
    out_ready  = 1'b0;
    phase_colors[0] = 8'h00;
    phase_colors[1] = 8'hFF;
    phase_colors[2] = attr_t'($urandom_range(255));
    phase_colors[3] = attr_t'($urandom_range(255));
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset color: the screen after reset, reads past
    // the screen, extreme characters, and a newline that is never stored.
    send_request(MODE_READ, 8'h00, 11'd0);
    send_request(MODE_READ, 8'hFF, index_t'(CELL_COUNT - 1));
    send_request(MODE_READ, 8'h00, index_t'(CELL_COUNT));
    send_request(MODE_READ, 8'h00, 11'h7FF);
    send_request(MODE_PUT, 8'h00, 11'd0);
    send_request(MODE_PUT, 8'hFF, 11'h7FF);
    send_request(MODE_PUT, 8'h41, 11'd0);
    send_request(MODE_PUT, NEWLINE_CODE, 11'd0);
    send_request(MODE_READ, 8'h00, 11'd0);
    send_request(MODE_READ, 8'h00, 11'd1);
    send_request(MODE_READ, 8'h00, 11'd2);
    send_request(MODE_READ, 8'h00, 11'd3);
    send_request(MODE_PUT, NEWLINE_CODE, 11'd0);
    send_request(MODE_PUT, 8'h7F, 11'd0);
    send_request(MODE_PUT, 8'h80, 11'd0);
    send_request(MODE_READ, 8'h00, index_t'(2 * COLUMNS));
    send_request(MODE_READ, 8'h00, index_t'(2 * COLUMNS + 1));
    send_request(MODE_READ, 8'h00, index_t'(COLUMNS));
    send_request(MODE_READ, NEWLINE_CODE, 11'h400);
    send_request(MODE_PUT, SPACE_CODE, 11'h7FF);

    // Random phases, each under its own text color.
    for (int unsigned p = 0; p < PHASES; p++) begin
      settle();
      write_color(phase_colors[p]);
      run_random(RANDOM_ITEMS / PHASES, p);
    end
    settle();

    $display("Sent %0d puts and %0d reads over %0d text colors; the screen scrolled %0d times.",
             sb.put_count, sb.read_count, PHASES + 1, sb.scroll_count);
    $display("Compared %0d results: %0d mismatches, %0d still outstanding.",
             sb.checked_count, sb.error_count, sb.pending_count());
    if (sb.error_count == 0 && sb.pending_count() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* text_terminal_cursor_scroll.f */
+incdir+hdl
hdl/tcs_pkg.sv
hdl/tcs_ram.sv
hdl/text_terminal_cursor_scroll.sv
test/text_terminal_cursor_scroll_tb.sv
